### hw/rtl/pct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants of the pending command tracker.
// ----------------------------------------------------------------------------
package pct_pkg;

  // Item codes.
  typedef logic [1:0] item_cmd_t;
  localparam item_cmd_t CMD_ISSUE    = 2'd0;
  localparam item_cmd_t CMD_RESPONSE = 2'd1;
  localparam item_cmd_t CMD_TICK     = 2'd2;

  // Node ids at or above this value are rejected on issue.
  localparam logic [7:0] FEEDER_COUNT = 8'd32;

  // Contents of one tracking slot.
  typedef struct packed {
    logic [31:0] sequence_num;
    logic [7:0]  feeder;
    logic [31:0] sent_time;
    logic [31:0] wait_limit;
    logic        need_reply;
    logic [7:0]  command_type;
  } slot_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;    // take the input item, restart the slot scan
    logic scan_read;  // read the slot at the scan index and advance
    logic finish;     // load the result register and update counters
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    item_cmd_t in_cmd;    // code of the item offered on the input
    logic      scan_last; // scan index points at the last slot
    logic      out_free;  // result register can take a new result
  } dp_status_t;

endpackage : pct_pkg
`default_nettype wire

### hw/rtl/pending_command_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pending_command_tracker
// Tracks outstanding commands to remote nodes with per-slot timeouts.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one item: cmd 0 issues a command,
// cmd 1 reports a response, cmd 2 is a time tick. Output channel
// (out_valid/out_ready) returns exactly one result per item, with flags and
// the four running counters as they stand after that item.
// An item is taken only while the sequencer is idle. Issue, response and tick
// items walk all SLOT_COUNT slots through the slot memory, one slot read per
// cycle; a drain state then evaluates the last read and the done state loads
// the result. Only then can the next item be taken, so an item is not accepted
// before the result of the previous one is loaded. The unused code skips the
// scan and goes straight to the done state.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and waits before loading the next one.
// Reset clears all waiting bits, the counters and both valid flags, and sets
// the next sequence number to one. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pending_command_tracker #(
  parameter int SLOT_COUNT = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [1:0]   cmd,
  input  wire [7:0]   feeder_id,
  input  wire         target_online,
  input  wire [7:0]   command_type,
  input  wire [31:0]  wait_limit_ms,
  input  wire         need_reply,
  input  wire         send_ok,
  input  wire [31:0]  response_sequence,
  input  wire [31:0]  now_ms,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        accepted,
  output logic [31:0] sequence_out,
  output logic        tracked,
  output logic        matched,
  output logic [7:0]  matched_command_type,
  output logic        matched_need_reply,
  output logic [6:0]  expired_count,
  output logic [31:0] commands_sent_total,
  output logic [31:0] responses_total,
  output logic [31:0] timeouts_total,
  output logic [31:0] errors_total
);
  import pct_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t stat;

  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  pct_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .ctl                  (ctl),
    .stat                 (stat),
    .cmd                  (cmd),
    .feeder_id            (feeder_id),
    .target_online        (target_online),
    .command_type         (command_type),
    .wait_limit_ms        (wait_limit_ms),
    .need_reply           (need_reply),
    .send_ok              (send_ok),
    .response_sequence    (response_sequence),
    .now_ms               (now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .accepted             (accepted),
    .sequence_out         (sequence_out),
    .tracked              (tracked),
    .matched              (matched),
    .matched_command_type (matched_command_type),
    .matched_need_reply   (matched_need_reply),
    .expired_count        (expired_count),
    .commands_sent_total  (commands_sent_total),
    .responses_total      (responses_total),
    .timeouts_total       (timeouts_total),
    .errors_total         (errors_total)
  );

endmodule : pending_command_tracker
`default_nettype wire

### hw/rtl/pct_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer: accepts an item, walks the slot scan, then hands off the result.
// ----------------------------------------------------------------------------
module pct_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  output pct_pkg::ctl_cmd_t      ctl,
  input  pct_pkg::dp_status_t    stat
);
  import pct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          // The unused code skips the scan entirely.
          if (stat.in_cmd == CMD_ISSUE || stat.in_cmd == CMD_RESPONSE ||
              stat.in_cmd == CMD_TICK) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        ctl.scan_read = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last slot read is being evaluated this cycle.
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : pct_ctrl
`default_nettype wire

### hw/rtl/pct_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_datapath
// Item registers, slot memory with waiting bits, scan evaluation, counters
// and the result register.
// ----------------------------------------------------------------------------
module pct_datapath #(
  parameter int SLOT_COUNT = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  pct_pkg::ctl_cmd_t    ctl,
  output pct_pkg::dp_status_t  stat,
  input  wire [1:0]            cmd,
  input  wire [7:0]            feeder_id,
  input  wire                  target_online,
  input  wire [7:0]            command_type,
  input  wire [31:0]           wait_limit_ms,
  input  wire                  need_reply,
  input  wire                  send_ok,
  input  wire [31:0]           response_sequence,
  input  wire [31:0]           now_ms,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 accepted,
  output logic [31:0]          sequence_out,
  output logic                 tracked,
  output logic                 matched,
  output logic [7:0]           matched_command_type,
  output logic                 matched_need_reply,
  output logic [6:0]           expired_count,
  output logic [31:0]          commands_sent_total,
  output logic [31:0]          responses_total,
  output logic [31:0]          timeouts_total,
  output logic [31:0]          errors_total
);
  import pct_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Captured item.
  item_cmd_t   cap_cmd;
  logic [7:0]  cap_feeder;
  logic        cap_online;
  logic [7:0]  cap_ctype;
  logic [31:0] cap_limit;
  logic        cap_reply;
  logic        cap_ok;
  logic [31:0] cap_rseq;
  logic [31:0] cap_now;

  // Slot storage.
  slot_entry_t            slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  slot_waiting;
  slot_entry_t            rd_data;

  // Scan pipeline: read stage then evaluate stage.
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_valid;

  // Per-item scan results.
  logic       found;
  logic [7:0] found_ctype;
  logic       found_reply;
  logic [6:0] expired_cnt;

  // Running state.
  logic [31:0] next_sequence;
  logic [31:0] sent_counter;
  logic [31:0] response_counter;
  logic [31:0] timeout_counter;
  logic [31:0] error_counter;

  logic        item_accepted;
  logic        issue_track;
  logic        cmp_waiting;
  logic [31:0] cmp_age;
  logic        do_claim;
  logic        do_match;
  logic        do_expire;
  slot_entry_t new_entry;

  logic [31:0] sent_counter_next;
  logic [31:0] error_counter_next;
  logic [31:0] response_counter_next;
  logic [31:0] timeout_counter_next;

  assign stat.in_cmd    = cmd;
  assign stat.scan_last = (scan_idx == IDX_W'(SLOT_COUNT - 1));
  assign stat.out_free  = !out_valid || out_ready;

  assign item_accepted = (cap_cmd == CMD_ISSUE) && (cap_feeder < FEEDER_COUNT) && cap_online;
  assign issue_track   = item_accepted && (cap_limit != 32'd0);

  assign cmp_waiting = slot_waiting[cmp_idx];
  // Age wraps modulo 2^32, so a sent time ahead of now reads as very old.
  assign cmp_age     = cap_now - rd_data.sent_time;

  assign do_claim  = cmp_valid && issue_track && !cmp_waiting && !found;
  assign do_match  = cmp_valid && (cap_cmd == CMD_RESPONSE) && cmp_waiting && !found &&
                     (rd_data.sequence_num == cap_rseq) && (rd_data.feeder == cap_feeder);
  assign do_expire = cmp_valid && (cap_cmd == CMD_TICK) && cmp_waiting &&
                     (cmp_age > rd_data.wait_limit);

  always_comb begin
    new_entry              = '0;
    new_entry.sequence_num = next_sequence;
    new_entry.feeder       = cap_feeder;
    new_entry.sent_time    = cap_now;
    new_entry.wait_limit   = cap_limit;
    new_entry.need_reply   = cap_reply;
    new_entry.command_type = cap_ctype;
  end

  always_comb begin
    sent_counter_next     = sent_counter;
    error_counter_next    = error_counter;
    response_counter_next = response_counter;
    timeout_counter_next  = timeout_counter + {25'd0, expired_cnt};
    if (item_accepted) begin
      if (cap_ok) begin
        sent_counter_next = sent_counter + 32'd1;
      end else begin
        error_counter_next = error_counter + 32'd1;
      end
    end
    if (cap_cmd == CMD_RESPONSE) begin
      response_counter_next = response_counter + 32'd1;
    end
  end

  // Item capture; payload only.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cap_cmd    <= cmd;
      cap_feeder <= feeder_id;
      cap_online <= target_online;
      cap_ctype  <= command_type;
      cap_limit  <= wait_limit_ms;
      cap_reply  <= need_reply;
      cap_ok     <= send_ok;
      cap_rseq   <= response_sequence;
      cap_now    <= now_ms;
    end
  end

  // Slot memory: one read at the scan index, one write at the evaluated index.
  always_ff @(posedge clk) begin
    if (ctl.scan_read) begin
      rd_data <= slot_mem[scan_idx];
    end
    if (do_claim) begin
      slot_mem[cmp_idx] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_waiting <= '0;
      scan_idx     <= '0;
      cmp_idx      <= '0;
      cmp_valid    <= 1'b0;
      found        <= 1'b0;
      found_ctype  <= '0;
      found_reply  <= 1'b0;
      expired_cnt  <= '0;
    end else begin
      cmp_valid <= ctl.scan_read;
      cmp_idx   <= scan_idx;
      if (ctl.capture) begin
        scan_idx    <= '0;
        found       <= 1'b0;
        found_ctype <= '0;
        found_reply <= 1'b0;
        expired_cnt <= '0;
      end else if (ctl.scan_read) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (do_claim) begin
        slot_waiting[cmp_idx] <= 1'b1;
        found                 <= 1'b1;
      end
      if (do_match) begin
        slot_waiting[cmp_idx] <= 1'b0;
        found                 <= 1'b1;
        found_ctype           <= rd_data.command_type;
        found_reply           <= rd_data.need_reply;
      end
      if (do_expire) begin
        slot_waiting[cmp_idx] <= 1'b0;
        expired_cnt           <= expired_cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sequence    <= 32'd1;
      sent_counter     <= '0;
      error_counter    <= '0;
      response_counter <= '0;
      timeout_counter  <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (ctl.finish) begin
        out_valid        <= 1'b1;
        sent_counter     <= sent_counter_next;
        error_counter    <= error_counter_next;
        response_counter <= response_counter_next;
        timeout_counter  <= timeout_counter_next;
        if (item_accepted) begin
          next_sequence <= next_sequence + 32'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      accepted             <= item_accepted;
      sequence_out         <= item_accepted ? next_sequence : 32'd0;
      tracked              <= issue_track && found;
      matched              <= (cap_cmd == CMD_RESPONSE) && found;
      matched_command_type <= (cap_cmd == CMD_RESPONSE) ? found_ctype : 8'd0;
      matched_need_reply   <= (cap_cmd == CMD_RESPONSE) && found_reply;
      expired_count        <= expired_cnt;
      commands_sent_total  <= sent_counter_next;
      responses_total      <= response_counter_next;
      timeouts_total       <= timeout_counter_next;
      errors_total         <= error_counter_next;
    end
  end

  // A result is never loaded over one that has not been taken.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // At most one slot is claimed or matched per item.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (found && cmp_valid) |-> !(do_claim || do_match))
    else $error("second slot hit in one scan");

  // A claimed slot is waiting from the next cycle on.
  a_claim_sets: assert property (@(posedge clk) disable iff (rst)
    do_claim |=> (slot_waiting[$past(cmp_idx)] && found))
    else $error("claimed slot not marked waiting");

  // Expiries in one scan cannot outnumber the slots.
  a_expired_bound: assert property (@(posedge clk) disable iff (rst)
    expired_cnt <= 7'(SLOT_COUNT))
    else $error("expiry count exceeds slot count");

endmodule : pct_datapath
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pending command tracker. A short table of
// directed items covers rejection, send outcome, deadlines and matching, and
// random traffic follows in several mixes. Every result is compared field by field
// against a behavioral copy of the tracker kept in the bench, or the table's own values.
// ----------------------------------------------------------------------------
module tb_top;
  import pct_pkg::*;

  localparam int SLOT_COUNT   = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam item_cmd_t CMD_UNUSED = 2'd3;

  typedef enum int {MIX_FLOOD, MIX_BALANCED, MIX_EXPIRY, MIX_NOISE} traffic_mix_t;

  typedef struct packed {
    item_cmd_t   code;
    logic [7:0]  node;
    logic        online;
    logic [7:0]  op;
    logic [31:0] limit;
    logic        reply;
    logic        sent_ok;
    logic [31:0] rseq;
    logic [31:0] stamp;
  } tracker_item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] seq_out;
    logic        tracked;
    logic        matched;
    logic [7:0]  m_type;
    logic        m_reply;
    logic [6:0]  expired;
    logic [31:0] sent, resp, tmo, err;
  } tracker_result_t;

  typedef struct packed {
    tracker_item_t   item;
    logic            typed;
    tracker_result_t result;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [7:0]  feeder_id;
  logic        target_online;
  logic [7:0]  command_type;
  logic [31:0] wait_limit_ms;
  logic        need_reply;
  logic        send_ok;
  logic [31:0] response_sequence;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_ready;
  logic        accepted;
  logic [31:0] sequence_out;
  logic        tracked;
  logic        matched;
  logic [7:0]  matched_command_type;
  logic        matched_need_reply;
  logic [6:0]  expired_count;
  logic [31:0] commands_sent_total;
  logic [31:0] responses_total;
  logic [31:0] timeouts_total;
  logic [31:0] errors_total;

  pending_command_tracker #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_top (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .cmd                  (cmd),
    .feeder_id            (feeder_id),
    .target_online        (target_online),
    .command_type         (command_type),
    .wait_limit_ms        (wait_limit_ms),
    .need_reply           (need_reply),
    .send_ok              (send_ok),
    .response_sequence    (response_sequence),
    .now_ms               (now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .accepted             (accepted),
    .sequence_out         (sequence_out),
    .tracked              (tracked),
    .matched              (matched),
    .matched_command_type (matched_command_type),
    .matched_need_reply   (matched_need_reply),
    .expired_count        (expired_count),
    .commands_sent_total  (commands_sent_total),
    .responses_total      (responses_total),
    .timeouts_total       (timeouts_total),
    .errors_total         (errors_total)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench copy of the tracker state.
  logic        pend_busy  [SLOT_COUNT];
  logic [31:0] pend_seq   [SLOT_COUNT];
  logic [7:0]  pend_node  [SLOT_COUNT];
  logic [31:0] pend_stamp [SLOT_COUNT];
  logic [31:0] pend_limit [SLOT_COUNT];
  logic        pend_reply [SLOT_COUNT];
  logic [7:0]  pend_op    [SLOT_COUNT];
  logic [31:0] seq_next;
  logic [31:0] n_sent, n_resp, n_timeout, n_fail;

  tracker_result_t due_results [$];
  stim_row_t       directed_rows [$];
  tracker_result_t want;

  logic [31:0] clock_ms;
  logic        tail_quiet;
  int          tx_calm;
  int          rx_hold;
  int          rx_calm;
  int          fail_count;
  int          results_seen;
  int          cycle_count;
  int          item_tally [4];
  int          untracked_full;
  int          matched_tally;

  function automatic tracker_result_t apply_item(input tracker_item_t it);
    tracker_result_t r;
    logic [31:0]     age;
    logic            done;
    r = '0;
    done = 1'b0;
    case (it.code)
      CMD_ISSUE: begin
        if (it.node < FEEDER_COUNT && it.online) begin
          r.accepted = 1'b1;
          r.seq_out = seq_next;
          seq_next = seq_next + 1;
          if (it.limit != 0) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!done && !pend_busy[i]) begin
                pend_busy[i]  = 1'b1;
                pend_seq[i]   = r.seq_out;
                pend_node[i]  = it.node;
                pend_stamp[i] = it.stamp;
                pend_limit[i] = it.limit;
                pend_reply[i] = it.reply;
                pend_op[i]    = it.op;
                r.tracked = 1'b1;
                done = 1'b1;
              end
            end
          end
          if (it.sent_ok) n_sent = n_sent + 1;
          else n_fail = n_fail + 1;
        end
      end
      CMD_RESPONSE: begin
        n_resp = n_resp + 1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!done && pend_busy[i] && pend_seq[i] == it.rseq && pend_node[i] == it.node) begin
            r.matched = 1'b1;
            r.m_type = pend_op[i];
            r.m_reply = pend_reply[i];
            pend_busy[i] = 1'b0;
            done = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          age = it.stamp - pend_stamp[i];
          if (pend_busy[i] && age > pend_limit[i]) begin
            pend_busy[i] = 1'b0;
            n_timeout = n_timeout + 1;
            r.expired = r.expired + 7'd1;
          end
        end
      end
      default: ;
    endcase
    r.sent = n_sent;
    r.resp = n_resp;
    r.tmo = n_timeout;
    r.err = n_fail;
    return r;
  endfunction

  function automatic tracker_item_t make_item(input item_cmd_t code, input logic [7:0] node,
      input logic online, input logic [7:0] op, input logic [31:0] limit, input logic reply,
      input logic sent_ok, input logic [31:0] rseq, input logic [31:0] stamp);
    tracker_item_t it;
    it.code = code;
    it.node = node;
    it.online = online;
    it.op = op;
    it.limit = limit;
    it.reply = reply;
    it.sent_ok = sent_ok;
    it.rseq = rseq;
    it.stamp = stamp;
    return it;
  endfunction

  function automatic tracker_result_t make_result(input logic acc, input logic [31:0] seq,
      input logic trk, input logic mat, input logic [7:0] mtype, input logic mrep,
      input logic [6:0] expd, input logic [31:0] sent, input logic [31:0] resp,
      input logic [31:0] tmo, input logic [31:0] err);
    tracker_result_t r;
    r.accepted = acc;
    r.seq_out = seq;
    r.tracked = trk;
    r.matched = mat;
    r.m_type = mtype;
    r.m_reply = mrep;
    r.expired = expd;
    r.sent = sent;
    r.resp = resp;
    r.tmo = tmo;
    r.err = err;
    return r;
  endfunction

  task automatic add_row(input tracker_item_t it, input logic typed, input tracker_result_t res);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // Random item shaped by the traffic mix. Fields that the code ignores
  // still carry noise.
  function automatic tracker_item_t draw_item(input traffic_mix_t mix);
    tracker_item_t it;
    int            live [$];
    int            roll;
    int            pick;
    int            stride;
    it.code    = CMD_TICK;
    it.node    = $urandom_range(0, 255);
    it.online  = $urandom_range(0, 1);
    it.op      = $urandom_range(0, 255);
    it.limit   = $urandom();
    it.reply   = $urandom_range(0, 1);
    it.sent_ok = $urandom_range(0, 1);
    it.rseq    = $urandom();
    it.stamp   = $urandom();
    if (mix == MIX_NOISE) begin
      it.code = $urandom_range(0, 3);
      return it;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (pend_busy[i]) live.push_back(i);
    end
    roll = $urandom_range(0, 99);
    it.stamp = clock_ms;
    if (roll < (mix == MIX_FLOOD ? 70 : mix == MIX_BALANCED ? 40 : 45)) begin
      it.code = CMD_ISSUE;
      if ($urandom_range(0, 9) != 0) it.node = $urandom_range(0, FEEDER_COUNT - 1);
      it.online = ($urandom_range(0, 9) != 0);
      case (mix)
        MIX_FLOOD:    it.limit = $urandom_range(5000, 100000);
        MIX_BALANCED: it.limit = $urandom_range(1, 400);
        default:      it.limit = $urandom_range(0, 60);
      endcase
      if ($urandom_range(0, 9) == 0) it.limit = '0;
      else if ($urandom_range(0, 19) == 0) it.limit = $urandom();
    end else if (roll < (mix == MIX_FLOOD ? 90 : mix == MIX_BALANCED ? 75 : 60)) begin
      it.code = CMD_RESPONSE;
      if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
        pick = live[$urandom_range(0, live.size() - 1)];
        it.node = pend_node[pick];
        it.rseq = pend_seq[pick];
        // Near misses: right sequence from the wrong node, or the reverse.
        case ($urandom_range(0, 9))
          0: it.node = it.node ^ (8'd1 << $urandom_range(0, 7));
          1: it.rseq = it.rseq + 1;
          default: ;
        endcase
      end else begin
        it.node = $urandom_range(0, FEEDER_COUNT - 1);
        it.rseq = seq_next - $urandom_range(0, 40);
      end
    end else if (mix == MIX_BALANCED && roll >= 97) begin
      it.code = CMD_UNUSED;
    end else begin
      it.code = CMD_TICK;
      stride = (mix == MIX_FLOOD) ? 20 : (mix == MIX_BALANCED) ? 150 : 80;
      clock_ms = clock_ms + $urandom_range(0, stride);
      if (mix == MIX_BALANCED && $urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom();
      it.stamp = clock_ms;
      // Land exactly on a slot's deadline, or one past it.
      if (mix == MIX_EXPIRY && live.size() != 0 && $urandom_range(0, 7) == 0) begin
        pick = live[$urandom_range(0, live.size() - 1)];
        it.stamp = pend_stamp[pick] + pend_limit[pick] + $urandom_range(0, 1);
      end
    end
    return it;
  endfunction

  function automatic int pick_gap();
    if (tail_quiet) return 0;
    if (tx_calm != 0) begin
      tx_calm = tx_calm - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      tx_calm = $urandom_range(10, 60);
      return 0;
    end
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 19);
    return 0;
  endfunction

  // Offers one item, holds it until the transfer, then records what it must produce.
  task automatic send_item(input tracker_item_t it, input logic typed,
                           input tracker_result_t typed_res, input int gap);
    tracker_result_t predicted;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd               <= it.code;
    feeder_id         <= it.node;
    target_online     <= it.online;
    command_type      <= it.op;
    wait_limit_ms     <= it.limit;
    need_reply        <= it.reply;
    send_ok           <= it.sent_ok;
    response_sequence <= it.rseq;
    now_ms            <= it.stamp;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_item(it);
    due_results.push_back(typed ? typed_res : predicted);
    item_tally[it.code] = item_tally[it.code] + 1;
    if (predicted.accepted && it.limit != 0 && !predicted.tracked)
      untracked_full = untracked_full + 1;
    if (predicted.matched) matched_tally = matched_tally + 1;
  endtask

  task automatic run_mix(input traffic_mix_t mix, input int count);
    tracker_item_t it;
    repeat (count) begin
      it = draw_item(mix);
      send_item(it, 1'b0, '0, pick_gap());
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      fail_count = fail_count + 1;
    end
  endtask

  // Receiver: stalls in random bursts, with calm stretches between.
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else if (!tail_quiet && rx_calm == 0 && $urandom_range(0, 9) == 0) begin
      rx_hold = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_calm != 0) rx_calm = rx_calm - 1;
      else if ($urandom_range(0, 63) == 0) rx_calm = $urandom_range(20, 150);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        fail_count = fail_count + 1;
      end else begin
        want = due_results.pop_front();
        check_field("accepted", want.accepted, accepted);
        check_field("sequence_out", want.seq_out, sequence_out);
        check_field("tracked", want.tracked, tracked);
        check_field("matched", want.matched, matched);
        check_field("matched_command_type", want.m_type, matched_command_type);
        check_field("matched_need_reply", want.m_reply, matched_need_reply);
        check_field("expired_count", want.expired, expired_count);
        check_field("commands_sent_total", want.sent, commands_sent_total);
        check_field("responses_total", want.resp, responses_total);
        check_field("timeouts_total", want.tmo, timeouts_total);
        check_field("errors_total", want.err, errors_total);
      end
      results_seen = results_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, due_results.size());
      $display("pending_command_tracker test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_ISSUE;
    feeder_id = '0;
    target_online = 1'b0;
    command_type = '0;
    wait_limit_ms = '0;
    need_reply = 1'b0;
    send_ok = 1'b0;
    response_sequence = '0;
    now_ms = '0;
    tail_quiet = 1'b0;
    tx_calm = 0;
    untracked_full = 0;
    matched_tally = 0;
    for (int k = 0; k < 4; k++) item_tally[k] = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pend_busy[i] = 1'b0;
      pend_seq[i] = '0;
      pend_node[i] = '0;
      pend_stamp[i] = '0;
      pend_limit[i] = '0;
      pend_reply[i] = 1'b0;
      pend_op[i] = '0;
    end
    seq_next = 32'd1;
    n_sent = '0;
    n_resp = '0;
    n_timeout = '0;
    n_fail = '0;

    // Empty tracker, then rejections of every kind.
    add_row(make_item(CMD_TICK, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0), 1'b1,
            make_result(1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    add_row(make_item(CMD_RESPONSE, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0), 1'b1,
            make_result(1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0, 7'd0, 32'd0, 32'd1, 32'd0, 32'd0));
    add_row(make_item(CMD_RESPONSE, 8'hFF, 1'b1, 8'hFF, '1, 1'b1, 1'b1, '1, '1), 1'b1,
            make_result(1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0, 7'd0, 32'd0, 32'd2, 32'd0, 32'd0));
    add_row(make_item(CMD_ISSUE, FEEDER_COUNT, 1'b1, 8'h11, 32'd5, 1'b1, 1'b1, 32'd0, 32'd0),
            1'b1,
            make_result(1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0, 7'd0, 32'd0, 32'd2, 32'd0, 32'd0));
    add_row(make_item(CMD_ISSUE, 8'hFF, 1'b1, 8'hFF, '1, 1'b1, 1'b0, '1, '1), 1'b1,
            make_result(1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0, 7'd0, 32'd0, 32'd2, 32'd0, 32'd0));
    add_row(make_item(CMD_ISSUE, 8'd0, 1'b0, 8'd0, 32'd10, 1'b0, 1'b1, 32'd0, 32'd0), 1'b1,
            make_result(1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0, 7'd0, 32'd0, 32'd2, 32'd0, 32'd0));
    // First accepted issues: longest limit tracked, zero limit untracked and failed send.
    add_row(make_item(CMD_ISSUE, FEEDER_COUNT - 8'd1, 1'b1, 8'hFF, '1, 1'b1, 1'b1, 32'd0,
                      32'hFFFF_FFF0), 1'b1,
            make_result(1'b1, 32'd1, 1'b1, 1'b0, 8'd0, 1'b0, 7'd0, 32'd1, 32'd2, 32'd0, 32'd0));
    add_row(make_item(CMD_ISSUE, 8'd0, 1'b1, 8'd0, 32'd0, 1'b1, 1'b0, 32'd0, 32'd0), 1'b1,
            make_result(1'b1, 32'd2, 1'b0, 1'b0, 8'd0, 1'b0, 7'd0, 32'd1, 32'd2, 32'd0, 32'd1));
    // Deadline across the time wrap: age equal to the limit survives, one more expires.
    add_row(make_item(CMD_ISSUE, 8'd7, 1'b1, 8'h5A, 32'd10, 1'b0, 1'b1, 32'd0, 32'hFFFF_FFFC),
            1'b0, '0);
    add_row(make_item(CMD_TICK, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd6), 1'b0, '0);
    add_row(make_item(CMD_TICK, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd7), 1'b0, '0);
    // Matching needs both sequence and node.
    add_row(make_item(CMD_ISSUE, 8'd3, 1'b1, 8'hA5, 32'd1000, 1'b0, 1'b0, 32'd0, 32'd7),
            1'b0, '0);
    add_row(make_item(CMD_RESPONSE, 8'd4, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd4, 32'd8),
            1'b0, '0);
    add_row(make_item(CMD_RESPONSE, 8'd3, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd5, 32'd8),
            1'b0, '0);
    add_row(make_item(CMD_RESPONSE, 8'd3, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd4, 32'd8),
            1'b0, '0);
    add_row(make_item(CMD_RESPONSE, 8'd31, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd1, 32'd9),
            1'b0, '0);
    add_row(make_item(CMD_RESPONSE, 8'd31, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd1, 32'd9),
            1'b0, '0);
    add_row(make_item(CMD_UNUSED, 8'hFF, 1'b1, 8'hFF, '1, 1'b1, 1'b1, '1, '1), 1'b0, '0);
    add_row(make_item(CMD_TICK, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'h8000_0000),
            1'b0, '0);
    // Shortest nonzero limit: no expiry at age zero, expiry at age two.
    add_row(make_item(CMD_ISSUE, 8'd31, 1'b1, 8'd0, 32'd1, 1'b1, 1'b1, 32'd0, 32'h8000_0000),
            1'b0, '0);
    add_row(make_item(CMD_TICK, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'h8000_0000),
            1'b0, '0);
    add_row(make_item(CMD_TICK, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'h8000_0002),
            1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < directed_rows.size(); k++)
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].result,
                pick_gap());
    wait_for_results();

    // Start just short of the time wrap so random traffic crosses it.
    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
    run_mix(MIX_FLOOD, 120);
    wait_for_results();
    run_mix(MIX_BALANCED, 300);
    run_mix(MIX_EXPIRY, 200);
    wait_for_results();
    run_mix(MIX_NOISE, 130);
    tail_quiet = 1'b1;
    run_mix(MIX_BALANCED, 180);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d issues (%0d untracked with all slots busy), %0d responses",
             item_tally[CMD_ISSUE], untracked_full, item_tally[CMD_RESPONSE]);
    $display("(%0d matched), %0d ticks (%0d expiries), %0d unused codes; %0d results checked.",
             matched_tally, item_tally[CMD_TICK], n_timeout, item_tally[CMD_UNUSED],
             results_seen);
    if (fail_count == 0)
      $display("pending_command_tracker test passed");
    else
      $display("pending_command_tracker test failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pct_pkg.sv
hw/rtl/pct_ctrl.sv
hw/rtl/pct_datapath.sv
hw/rtl/pending_command_tracker.sv
test/tb_top.sv
